### hdl/piq_pkg.sv
// Shared types, constants and entry functions for the priority insert queue.
package piq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int LEVEL_BITS  = 16;
	localparam int FIELD_BITS  = 16;
	localparam int DECAY_BITS  = 16;
	localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUB_BITS    = (LEVEL_BITS > DECAY_BITS) ? LEVEL_BITS : DECAY_BITS;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_DECAY  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] id;
		logic [FIELD_BITS-1:0] tag;
		logic                  urgent;
		logic [LEVEL_BITS-1:0] level;
	} slot_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic dec;
	} ctl_t;

	function automatic logic beats(input slot_t a, input slot_t b);
		logic win;
		win = (a.urgent && !b.urgent) || ((a.urgent == b.urgent) && (a.level < b.level));
		return win;
	endfunction

	function automatic slot_t decay_slot(input slot_t s, input logic [DECAY_BITS-1:0] amt);
		slot_t                r;
		logic [SUB_BITS-1:0] lvl;
		logic [SUB_BITS-1:0] sub;
		r   = s;
		lvl = SUB_BITS'(s.level);
		sub = SUB_BITS'(amt);
		if (lvl <= sub) begin
			r.level  = LEVEL_BITS'(1);
			r.urgent = 1'b1;
		end else begin
			r.level = LEVEL_BITS'(lvl - sub);
		end
		return r;
	endfunction

endpackage

### hdl/piq_cell.sv
// One queue slot: compares, shifts toward either neighbor, or decays its level.
module piq_cell
	import piq_pkg::*;
(
	input  logic                  clk,
	input  ctl_t                  ctl,
	input  slot_t                 new_slot,
	input  logic [DECAY_BITS-1:0] decay_amt,
	input  logic                  occupied,
	input  logic                  at_tail,
	input  logic                  left_beaten,
	input  slot_t                 left_slot,
	input  slot_t                 right_slot,
	output logic                  beaten,
	output slot_t                 slot
);

	slot_t slot_q;
	logic  beat_here;

	assign beat_here = occupied && beats(new_slot, slot_q);
	assign beaten    = left_beaten || beat_here;
	assign slot      = slot_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_beaten) begin
				slot_q <= left_slot;
			end else if (beat_here || at_tail) begin
				slot_q <= new_slot;
			end
		end else if (ctl.pop) begin
			slot_q <= right_slot;
		end else if (ctl.dec) begin
			slot_q <= decay_slot(slot_q, decay_amt);
		end
	end

endmodule

### hdl/priority_insert_queue_with_aging_top.sv
// Top level of the priority insert queue: command decode, entry count and the cell row.
// Results are registered: the result of a command shows on the result ports in the cycle after it is taken.
// Throughput: one command per cycle; the cell row handles insert, pop and decay in a single step.
// busy stays low, so a command is taken whenever start is high.
// Reset clears the entry count and sets the decay amount to 1; slot contents are not cleared.
module priority_insert_queue_with_aging_top
	import piq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [FIELD_BITS-1:0] entry_id,
	input  logic [FIELD_BITS-1:0] entry_tag,
	input  logic                  entry_urgent,
	input  logic [FIELD_BITS-1:0] entry_level,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DECAY_BITS-1:0] cfg_data,
	output logic                  done,
	output logic                  head_valid,
	output logic [FIELD_BITS-1:0] head_id,
	output logic [FIELD_BITS-1:0] head_tag,
	output logic                  head_urgent,
	output logic [FIELD_BITS-1:0] head_level,
	output logic                  dropped,
	output logic [COUNT_BITS-1:0] occupancy
);

	logic [COUNT_BITS-1:0] count_q;
	logic [DECAY_BITS-1:0] decay_q;
	logic                  done_q;
	logic                  head_valid_q;
	logic                  dropped_q;
	logic [COUNT_BITS-1:0] occupancy_q;
	slot_t                 head_q;

	logic                  accept;
	cmd_t                  op;
	logic                  full;
	logic                  empty;
	ctl_t                  ctl;
	slot_t                 new_slot;
	logic [COUNT_BITS-1:0] count_next;

	slot_t slots [QUEUE_DEPTH];
	logic  beat_chain [QUEUE_DEPTH+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign op        = cmd_t'(cmd);
	assign full      = (count_q == COUNT_BITS'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign ctl.ins = accept && (op == CMD_INSERT) && !full;
	assign ctl.pop = accept && (op == CMD_POP) && !empty;
	assign ctl.dec = accept && (op == CMD_DECAY);

	assign new_slot.id     = entry_id;
	assign new_slot.tag    = entry_tag;
	assign new_slot.urgent = entry_urgent;
	assign new_slot.level  = LEVEL_BITS'(entry_level);

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + COUNT_BITS'(1);
		end else if (ctl.pop) begin
			count_next = count_q - COUNT_BITS'(1);
		end
	end

	assign beat_chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t left_slot;
		slot_t right_slot;
		if (i == 0) begin : g_first
			assign left_slot = new_slot;
		end else begin : g_mid
			assign left_slot = slots[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_slot = slots[i];
		end else begin : g_inner
			assign right_slot = slots[i+1];
		end
		piq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_slot    (new_slot),
			.decay_amt   (decay_q),
			.occupied    (COUNT_BITS'(i) < count_q),
			.at_tail     (COUNT_BITS'(i) == count_q),
			.left_beaten (beat_chain[i]),
			.left_slot   (left_slot),
			.right_slot  (right_slot),
			.beaten      (beat_chain[i+1]),
			.slot        (slots[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			decay_q      <= DECAY_BITS'(1);
			done_q       <= 1'b0;
			head_valid_q <= 1'b0;
			dropped_q    <= 1'b0;
			occupancy_q  <= '0;
		end else begin
			done_q <= accept;
			if (cfg_valid && cfg_ready) begin
				decay_q <= cfg_data;
			end
			if (accept) begin
				count_q      <= count_next;
				occupancy_q  <= count_next;
				head_valid_q <= ctl.pop;
				dropped_q    <= (op == CMD_INSERT) && full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (ctl.pop) begin
				head_q <= slots[0];
			end else begin
				head_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign head_valid  = head_valid_q;
	assign head_id     = head_q.id;
	assign head_tag    = head_q.tag;
	assign head_urgent = head_q.urgent;
	assign head_level  = FIELD_BITS'(head_q.level);
	assign dropped     = dropped_q;
	assign occupancy   = occupancy_q;

endmodule

### hdl/piq_checker.sv
// Port-level assertions for the priority insert queue, bound to the top level.
module piq_checker
	import piq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [1:0]            cmd,
	input logic                  done,
	input logic                  head_valid,
	input logic [FIELD_BITS-1:0] head_id,
	input logic [FIELD_BITS-1:0] head_tag,
	input logic                  head_urgent,
	input logic [FIELD_BITS-1:0] head_level,
	input logic                  dropped,
	input logic [COUNT_BITS-1:0] occupancy
);

	a_one_beat_per_command: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("A taken command did not produce a result beat.");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (occupancy == COUNT_BITS'(QUEUE_DEPTH)))
		else $error("An insert was dropped while the queue had room.");

	a_pop_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(head_valid && dropped))
		else $error("A result beat shows both a popped entry and a drop.");

	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !head_valid) |-> (head_id == '0 && head_tag == '0 && !head_urgent
			&& head_level == '0))
		else $error("A result beat without a popped entry carries head data.");

	a_pop_valid_lowers_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_POP) |=> (head_valid || occupancy == '0))
		else $error("A pop on a non-empty queue returned no entry.");

endmodule

bind priority_insert_queue_with_aging_top piq_checker u_piq_checker (.*);

### tb/tb.sv
// Self-checking testbench for the priority insert queue with aging.
`timescale 1ns / 1ps

module tb;
	import piq_pkg::*;

	typedef struct packed {
		logic                  valid;
		logic [FIELD_BITS-1:0] id;
		logic [FIELD_BITS-1:0] tag;
		logic                  urgent;
		logic [FIELD_BITS-1:0] level;
		logic                  dropped;
		logic [COUNT_BITS-1:0] occ;
	} head_result_t;

	typedef struct packed {
		logic [1:0]            op;
		slot_t                 ent;
		logic                  fixed;
		logic                  drop;
		logic [COUNT_BITS-1:0] occ;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            cmd;
	logic [FIELD_BITS-1:0] entry_id;
	logic [FIELD_BITS-1:0] entry_tag;
	logic                  entry_urgent;
	logic [FIELD_BITS-1:0] entry_level;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [DECAY_BITS-1:0] cfg_data;
	logic                  done;
	logic                  head_valid;
	logic [FIELD_BITS-1:0] head_id;
	logic [FIELD_BITS-1:0] head_tag;
	logic                  head_urgent;
	logic [FIELD_BITS-1:0] head_level;
	logic                  dropped;
	logic [COUNT_BITS-1:0] occupancy;

	slot_t                 queue_slots [QUEUE_DEPTH];
	int                    queue_count = 0;
	logic [DECAY_BITS-1:0] queue_decay = 1;
	head_result_t          pending_heads [$];
	dir_row_t              dir_rows [$];
	logic                  fix_on;
	head_result_t          fix_res;

	int errors = 0;
	int checked = 0;
	int cmds_taken = 0;
	int cfg_taken = 0;
	int n_ins = 0;
	int n_drop = 0;
	int n_pop = 0;
	int n_empty = 0;
	int n_decay = 0;
	int n_nop = 0;

	priority_insert_queue_with_aging_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.entry_id    (entry_id),
		.entry_tag   (entry_tag),
		.entry_urgent(entry_urgent),
		.entry_level (entry_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.head_valid  (head_valid),
		.head_id     (head_id),
		.head_tag    (head_tag),
		.head_urgent (head_urgent),
		.head_level  (head_level),
		.dropped     (dropped),
		.occupancy   (occupancy)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic head_result_t queue_apply(input cmd_t op, input slot_t e);
		head_result_t r;
		int           pos;
		int           i;
		bit           found;
		r = '0;
		case (op)
			CMD_INSERT: begin
				if (queue_count >= QUEUE_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					pos   = queue_count;
					found = 0;
					for (i = 0; i < queue_count; i++) begin
						if (!found && ((e.urgent && !queue_slots[i].urgent) ||
						    (e.urgent == queue_slots[i].urgent &&
						     e.level < queue_slots[i].level))) begin
							pos   = i;
							found = 1;
						end
					end
					for (i = queue_count; i > pos; i--)
						queue_slots[i] = queue_slots[i-1];
					queue_slots[pos] = e;
					queue_count++;
				end
			end
			CMD_POP: begin
				if (queue_count > 0) begin
					r.valid  = 1'b1;
					r.id     = queue_slots[0].id;
					r.tag    = queue_slots[0].tag;
					r.urgent = queue_slots[0].urgent;
					r.level  = FIELD_BITS'(queue_slots[0].level);
					for (i = 1; i < queue_count; i++)
						queue_slots[i-1] = queue_slots[i];
					queue_count--;
				end
			end
			CMD_DECAY: begin
				for (i = 0; i < queue_count; i++) begin
					if (queue_slots[i].level <= queue_decay) begin
						queue_slots[i].level  = LEVEL_BITS'(1);
						queue_slots[i].urgent = 1'b1;
					end else begin
						queue_slots[i].level = LEVEL_BITS'(queue_slots[i].level - queue_decay);
					end
				end
			end
			default: begin
			end
		endcase
		r.occ = COUNT_BITS'(queue_count);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		head_result_t want;
		head_result_t pred;
		slot_t        e;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_heads.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected", $time);
				end else begin
					want = pending_heads.pop_front();
					checked++;
					check_field("head_valid", 32'(want.valid), 32'(head_valid));
					check_field("head_id", 32'(want.id), 32'(head_id));
					check_field("head_tag", 32'(want.tag), 32'(head_tag));
					check_field("head_urgent", 32'(want.urgent), 32'(head_urgent));
					check_field("head_level", 32'(want.level), 32'(head_level));
					check_field("dropped", 32'(want.dropped), 32'(dropped));
					check_field("occupancy", 32'(want.occ), 32'(occupancy));
				end
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				queue_decay = cfg_data;
				cfg_taken++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				e.id     = entry_id;
				e.tag    = entry_tag;
				e.urgent = entry_urgent;
				e.level  = LEVEL_BITS'(entry_level);
				pred     = queue_apply(cmd_t'(cmd), e);
				case (cmd_t'(cmd))
					CMD_INSERT: begin
						n_ins++;
						if (pred.dropped)
							n_drop++;
					end
					CMD_POP: begin
						n_pop++;
						if (!pred.valid)
							n_empty++;
					end
					CMD_DECAY: n_decay++;
					default:   n_nop++;
				endcase
				pending_heads.push_back(fix_on ? fix_res : pred);
				cmds_taken++;
			end
		end
	end

	function automatic slot_t random_entry();
		slot_t e;
		e.id     = FIELD_BITS'($urandom);
		e.tag    = FIELD_BITS'($urandom);
		e.urgent = ($urandom_range(0, 9) < 3);
		case ($urandom_range(0, 9))
			0:          e.level = '0;
			1:          e.level = '1;
			2, 3, 4, 5: e.level = LEVEL_BITS'($urandom_range(0, 12));
			default:    e.level = LEVEL_BITS'($urandom);
		endcase
		return e;
	endfunction

	task automatic send_cmd(input cmd_t op, input slot_t e, input bit fixed,
	                        input head_result_t fx, input bit no_gap);
		int gap;
		int seen;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        = 1'b1;
		cmd          = op;
		entry_id     = e.id;
		entry_tag    = e.tag;
		entry_urgent = e.urgent;
		entry_level  = FIELD_BITS'(e.level);
		fix_on       = fixed;
		fix_res      = fx;
		seen         = cmds_taken;
		do @(negedge clk); while (cmds_taken == seen);
	endtask

	task automatic write_decay(input logic [DECAY_BITS-1:0] v);
		int seen;
		start = 1'b0;
		while (pending_heads.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		seen      = cfg_taken;
		do @(negedge clk); while (cfg_taken == seen);
		cfg_valid = 1'b0;
	endtask

	task automatic add_row(input cmd_t op, input logic [15:0] id, input logic [15:0] tag,
	                       input logic urg, input logic [15:0] lvl, input bit fixed,
	                       input bit drop, input int occ);
		dir_row_t row;
		row.op         = op;
		row.ent.id     = id;
		row.ent.tag    = tag;
		row.ent.urgent = urg;
		row.ent.level  = LEVEL_BITS'(lvl);
		row.fixed      = fixed;
		row.drop       = drop;
		row.occ        = COUNT_BITS'(occ);
		dir_rows.push_back(row);
	endtask

	initial begin
		head_result_t          fx;
		dir_row_t              row;
		logic [DECAY_BITS-1:0] plan [6];
		cmd_t                  op;
		int                    p;
		int                    k;
		int                    r;
		int                    mode;
		bit                    burst;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_NOP;
		entry_id     = '0;
		entry_tag    = '0;
		entry_urgent = 1'b0;
		entry_level  = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		fix_on       = 1'b0;
		fix_res      = '0;

		add_row(CMD_POP,    16'h0000, 16'h0000, 1'b0, 16'h0000, 1, 0, 0);
		add_row(CMD_DECAY,  16'h0000, 16'h0000, 1'b0, 16'h0000, 1, 0, 0);
		add_row(CMD_NOP,    16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1, 0, 0);
		add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1, 0, 1);
		add_row(CMD_INSERT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1, 0, 2);
		add_row(CMD_INSERT, 16'h0001, 16'hAAAA, 1'b1, 16'h0000, 1, 0, 3);
		add_row(CMD_INSERT, 16'h0002, 16'h5555, 1'b0, 16'h0005, 1, 0, 4);
		add_row(CMD_INSERT, 16'h0003, 16'h1234, 1'b0, 16'h0005, 1, 0, 5);
		add_row(CMD_DECAY,  16'h0000, 16'h0000, 1'b0, 16'h0000, 0, 0, 0);
		add_row(CMD_POP,    16'h0000, 16'h0000, 1'b0, 16'h0000, 0, 0, 0);
		add_row(CMD_POP,    16'h0000, 16'h0000, 1'b0, 16'h0000, 0, 0, 0);
		add_row(CMD_INSERT, 16'h0004, 16'h0F0F, 1'b1, 16'h0001, 0, 0, 0);
		add_row(CMD_POP,    16'h0000, 16'h0000, 1'b0, 16'h0000, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < dir_rows.size(); k++) begin
			row       = dir_rows[k];
			fx        = '0;
			fx.dropped = row.drop;
			fx.occ    = row.occ;
			send_cmd(cmd_t'(row.op), row.ent, row.fixed, fx, 1'($urandom_range(0, 1)));
		end
		while (queue_count < QUEUE_DEPTH)
			send_cmd(CMD_INSERT, random_entry(), 0, '0, 0);
		fx         = '0;
		fx.dropped = 1'b1;
		fx.occ     = COUNT_BITS'(QUEUE_DEPTH);
		send_cmd(CMD_INSERT, random_entry(), 1, fx, 0);

		plan[0] = '0;
		plan[1] = '1;
		plan[2] = DECAY_BITS'(1);
		plan[3] = DECAY_BITS'(3);
		plan[4] = DECAY_BITS'($urandom);
		plan[5] = DECAY_BITS'(7);
		for (p = 0; p < 6; p++) begin
			write_decay(plan[p]);
			mode  = 0;
			burst = 0;
			for (k = 0; k < 320; k++) begin
				if (k % 40 == 0) begin
					mode  = $urandom_range(0, 2);
					burst = ($urandom_range(0, 3) == 0);
				end
				r = $urandom_range(0, 99);
				if (r >= 97)
					op = CMD_NOP;
				else if (r >= 85)
					op = CMD_DECAY;
				else if (r < ((mode == 0) ? 65 : (mode == 1) ? 25 : 45))
					op = CMD_INSERT;
				else
					op = CMD_POP;
				send_cmd(op, random_entry(), 0, '0, burst);
			end
		end

		start = 1'b0;
		while (pending_heads.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		$display("Ran %0d commands: %0d inserts (%0d refused on a full queue), %0d pops (%0d empty).",
		         cmds_taken, n_ins, n_drop, n_pop, n_empty);
		$display("Also %0d decay ticks over 7 decay settings and %0d unused codes; %0d beats checked.",
		         n_decay, n_nop, checked);
		if (errors == 0 && pending_heads.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout with %0d results still expected.", pending_heads.size());
		$display("tb failed");
		$finish;
	end

endmodule

### files.f
hdl/piq_pkg.sv
hdl/piq_cell.sv
hdl/priority_insert_queue_with_aging_top.sv
hdl/piq_checker.sv
tb/tb.sv
